@@ hw/rtl/lcs_length_engine_defines.svh @@
// Assertion helpers for the LCS length engine.
// All checks sample on the rising edge of clock and are off while reset is high.
`ifndef LCS_LENGTH_ENGINE_DEFINES_SVH
`define LCS_LENGTH_ENGINE_DEFINES_SVH

// Condition holds at every edge.
`define LCS_CHECK_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds at the same edge as the antecedent.
`define LCS_CHECK_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds at the edge after the antecedent.
`define LCS_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/lcs_pkg.sv @@
`default_nettype none

package lcs_pkg;

   localparam int unsigned MAX_LEN_DEF       = 64;
   localparam int unsigned SYMBOL_BITS_DEF   = 8;
   localparam int unsigned SYMBOL_FIELD_BITS = 8;
   localparam int unsigned LENGTH_FIELD_BITS = 7;
   localparam int unsigned LENGTH_MAX_OUT    = 127;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_QUERY = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef struct packed {
      action_type                   action;
      logic [SYMBOL_FIELD_BITS-1:0] symbol;
      logic                         last;
   } req_type;

   typedef struct packed {
      logic [LENGTH_FIELD_BITS-1:0] lcs_length;
      logic                         ref_overflow;
   } rsp_type;

   // Query symbol travelling down the cell chain.
   typedef struct packed {
      logic                         valid;
      logic                         last;
      logic [SYMBOL_FIELD_BITS-1:0] q;
   } tok_type;

   // Per-cell control decoded at the top level.
   typedef struct packed {
      logic                         clear;
      logic                         load;
      logic                         active;
      logic [SYMBOL_FIELD_BITS-1:0] load_sym;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/lcs_cell.sv @@
`default_nettype none

module lcs_cell #(
   parameter int unsigned LEN_BITS = 7,
   parameter int unsigned SYM_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lcs_pkg::cell_ctl_type ctl,
   input  lcs_pkg::tok_type      prev_tok,
   input  logic [LEN_BITS-1:0]   prev_diag,
   input  logic [LEN_BITS-1:0]   prev_left,
   output lcs_pkg::tok_type      out_tok,
   output logic [LEN_BITS-1:0]   out_diag,
   output logic [LEN_BITS-1:0]   out_left
);
   import lcs_pkg::*;

   logic [SYM_BITS-1:0] sym_ff;
   logic [LEN_BITS-1:0] dp_ff, dp_in;
   tok_type             tok_ff, tok_in;
   logic [LEN_BITS-1:0] diag_ff, diag_in;
   logic [LEN_BITS-1:0] left_ff, left_in;
   logic                hit;
   logic                match;
   logic [LEN_BITS-1:0] upd;

   always_comb begin
      hit     = prev_tok.valid && ctl.active;
      match   = (sym_ff == prev_tok.q[SYM_BITS-1:0]);
      upd     = match ? (prev_diag + LEN_BITS'(1)) :
                        ((dp_ff > prev_left) ? dp_ff : prev_left);
      tok_in  = prev_tok;
      diag_in = dp_ff;
      // Cells past the reference length pass the running value through.
      left_in = hit ? upd : prev_left;
      priority if (ctl.clear) begin
         dp_in = '0;
      end else if (hit) begin
         // The final symbol leaves a zeroed row for the next query.
         dp_in = prev_tok.last ? '0 : upd;
      end else begin
         dp_in = dp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         sym_ff <= ctl.load_sym[SYM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_ff  <= '0;
         tok_ff <= '0;
      end else begin
         dp_ff  <= dp_in;
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      diag_ff <= diag_in;
      left_ff <= left_in;
   end

   assign out_tok  = tok_ff;
   assign out_diag = diag_ff;
   assign out_left = left_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lcs_out_reg.sv @@
`default_nettype none

module lcs_out_reg #(
   parameter int unsigned LEN_BITS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [LEN_BITS-1:0] len,
   input  logic                overflow,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lcs_pkg::rsp_type    rsp_item
);
   import lcs_pkg::*;

   logic        valid_ff, valid_in;
   rsp_type     item_ff, item_in;
   logic [31:0] len_ext;

   always_comb begin
      len_ext = 32'(len);
      item_in = item_ff;
      if (load) begin
         item_in.lcs_length   = (len_ext > 32'(LENGTH_MAX_OUT)) ?
                                LENGTH_FIELD_BITS'(LENGTH_MAX_OUT) :
                                len_ext[LENGTH_FIELD_BITS-1:0];
         item_in.ref_overflow = overflow;
      end
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lcs_length_engine.sv @@
// LCS length engine.
// Input channel req_*: one beat per action. A load beat appends a reference
// symbol (dropped, with the sticky overflow flag set, once MAX_LEN are held),
// a query beat streams one query symbol, a clear beat empties the reference,
// the overflow flag and the DP row. Action code 3 is taken and ignored.
// Each reference symbol lives in one cell of a chain of MAX_LEN cells. A query
// symbol enters cell 0 in the cycle it is accepted and moves one cell per
// cycle, so query beats are taken back to back, one per cycle, unless a last beat must wait.
// The result beat on rsp_* (LCS length, overflow flag) for a query beat with
// last set is registered once that symbol leaves the last cell of the chain.
// Load and clear beats wait until no query symbol is left in the chain; the
// earliest one is taken once the latest query symbol has left the last cell.
// One result is held at a time: a last query beat waits while an earlier
// result is still in flight or not yet taken, so a stalled receiver holds up
// only the next last beat.
// Reset empties the reference, zeroes the row and clears the overflow flag;
// no clearing pass is needed.
`default_nettype none
`include "lcs_length_engine_defines.svh"

module lcs_length_engine #(
   parameter int unsigned MAX_LEN     = lcs_pkg::MAX_LEN_DEF,
   parameter int unsigned SYMBOL_BITS = lcs_pkg::SYMBOL_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lcs_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lcs_pkg::rsp_type rsp_item
);
   import lcs_pkg::*;

   localparam int unsigned SymW = (SYMBOL_BITS < SYMBOL_FIELD_BITS) ?
                                  SYMBOL_BITS : SYMBOL_FIELD_BITS;
   localparam int unsigned LenW = $clog2(MAX_LEN + 1);
   localparam int unsigned CntW = $clog2(MAX_LEN + 1);
   localparam logic [SYMBOL_FIELD_BITS-1:0] SymMask =
      SYMBOL_FIELD_BITS'((64'd1 << SymW) - 64'd1);

   logic            req_go, load_go, query_go, clear_go, last_go;
   logic            room;
   logic [CntW-1:0] count_ff, count_in;
   logic            overflow_ff, overflow_in;
   logic            pending_ff, pending_in;
   logic [CntW-1:0] flight_ff, flight_in;
   logic            exit_last;
   logic            rsp_done;

   tok_type         tok_chain  [0:MAX_LEN];
   logic [LenW-1:0] diag_chain [0:MAX_LEN];
   logic [LenW-1:0] left_chain [0:MAX_LEN];
   cell_ctl_type    ctl        [0:MAX_LEN-1];

   always_comb begin
      unique case (req_item.action)
         ACT_LOAD, ACT_CLEAR: req_ready = (flight_ff == '0);
         ACT_QUERY:           req_ready = !(req_item.last && pending_ff);
         ACT_NOP:             req_ready = 1'b1;
         default:             req_ready = 1'b1;
      endcase
   end

   assign req_go   = req_valid && req_ready;
   assign load_go  = req_go && (req_item.action == ACT_LOAD);
   assign query_go = req_go && (req_item.action == ACT_QUERY);
   assign clear_go = req_go && (req_item.action == ACT_CLEAR);
   assign last_go  = query_go && req_item.last;
   assign room     = (count_ff < CntW'(MAX_LEN));
   assign rsp_done = rsp_valid && rsp_ready;

   assign exit_last = tok_chain[MAX_LEN].valid && tok_chain[MAX_LEN].last;

   always_comb begin
      priority if (clear_go) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (load_go && room) begin
         count_in    = count_ff + CntW'(1);
         overflow_in = overflow_ff;
      end else if (load_go) begin
         count_in    = count_ff;
         overflow_in = 1'b1;
      end else begin
         count_in    = count_ff;
         overflow_in = overflow_ff;
      end
      priority if (last_go) begin
         pending_in = 1'b1;
      end else if (rsp_done) begin
         pending_in = 1'b0;
      end else begin
         pending_in = pending_ff;
      end
      // Track symbols inside the chain; loads and clears wait for it to drain.
      flight_in = flight_ff + CntW'(query_go) - CntW'(tok_chain[MAX_LEN].valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         pending_ff  <= 1'b0;
         flight_ff   <= '0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         pending_ff  <= pending_in;
         flight_ff   <= flight_in;
      end
   end

   always_comb begin
      tok_chain[0].valid = query_go;
      tok_chain[0].last  = req_item.last;
      tok_chain[0].q     = req_item.symbol & SymMask;
      diag_chain[0]      = '0;
      left_chain[0]      = '0;
   end

   for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
      always_comb begin
         ctl[j].clear    = clear_go;
         ctl[j].load     = load_go && (count_ff == CntW'(j));
         ctl[j].active   = (count_ff > CntW'(j));
         ctl[j].load_sym = req_item.symbol & SymMask;
      end

      lcs_cell #(
         .LEN_BITS (LenW),
         .SYM_BITS (SymW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[j]),
         .prev_tok  (tok_chain[j]),
         .prev_diag (diag_chain[j]),
         .prev_left (left_chain[j]),
         .out_tok   (tok_chain[j+1]),
         .out_diag  (diag_chain[j+1]),
         .out_left  (left_chain[j+1])
      );
   end

   lcs_out_reg #(
      .LEN_BITS (LenW)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (exit_last),
      .len       (left_chain[MAX_LEN]),
      .overflow  (overflow_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   `LCS_CHECK_SAME(a_exit_slot_free, exit_last, !rsp_valid, "result exits while one is held")
   `LCS_CHECK_SAME(a_ref_change_drained, load_go || clear_go, flight_ff == '0,
                   "reference changed with symbols in the chain")
   `LCS_CHECK_ALWAYS(a_flight_bound, flight_ff <= CntW'(MAX_LEN), "chain occupancy overrun")
   `LCS_CHECK_NEXT(a_single_result, rsp_done, !rsp_valid, "second result queued behind first")

endmodule

`default_nettype wire
